// File: rtl/core/dtmi_pkg.sv
// Package: constants for the double to modular integer converter.
`timescale 1ns / 1ps
package dtmi_pkg;
  localparam int FracBits = 52;
  localparam int ExpBits = 11;
  localparam logic [10:0] ExpAllOnes = 11'h7FF;
  localparam int ExpBiasShift = 1075;
  localparam int WordBits = 64;
  localparam int WidthBits = 7;
endpackage

// File: rtl/core/double_to_modular_integer.sv
// Top level: registered double to modular integer converter.
//   channel | signals                                    | handshake
//   input   | number_bits, target_width, want_signed      | start && !busy
//   output  | converted                                  | done strobe, one cycle
// One word in per cycle; each result appears in the cycle after its start.
// busy is always low. Reset clears the strobe. The receiver cannot stall.
`timescale 1ns / 1ps
module double_to_modular_integer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] number_bits,
  input  logic [6:0]  target_width,
  input  logic        want_signed,
  output logic        done,
  output logic [63:0] converted
);
  logic [10:0] e;
  logic [52:0] sig;
  logic [12:0] sh;
  logic [63:0] mag;
  logic [63:0] r;
  logic [63:0] mask;
  logic [6:0]  w;
  logic [63:0] converted_next;

  assign busy = 1'b0;

  always_comb begin
    e = number_bits[62:52];
    sig = {1'b1, number_bits[51:0]};
    sh = {2'b00, e} - 13'(dtmi_pkg::ExpBiasShift);
    if (e == 11'd0) begin
      mag = 64'd0;
    end else if (sh[12]) begin
      if ($signed(sh) <= -13'sd53) mag = 64'd0;
      else mag = 64'(sig >> (6'(-sh)));
    end else if (sh >= 13'd64) begin
      mag = 64'd0;
    end else begin
      mag = 64'(sig) << sh[5:0];
    end
    r = number_bits[63] ? (64'd0 - mag) : mag;
    w = (target_width > 7'd64) ? 7'd64 : target_width;
    mask = (w == 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
    r = r & mask;
    if (want_signed && w != 7'd0 && w != 7'd64) begin
      if (r[6'(w - 7'd1)]) r = r | ~mask;
    end
    converted_next = (e == dtmi_pkg::ExpAllOnes) ? 64'd0 : r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    converted <= converted_next;
  end
endmodule

// File: rtl/core/dtmi_checker.sv
// Checker: port-level assertions for the converter.
`timescale 1ns / 1ps
module dtmi_props (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [63:0] number_bits,
  input logic        done,
  input logic [63:0] converted
);
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done) else $error("missing result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !start |=> !done) else $error("spurious result");
  a_nan_zero: assert property (@(posedge clk) disable iff (rst)
    (start && number_bits[62:52] == 11'h7FF) |=> converted == 64'd0)
    else $error("nan or inf not zero");
endmodule

bind double_to_modular_integer dtmi_props u_dtmi_props (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .number_bits(number_bits), .done(done), .converted(converted)
);
